FILE: hdl/enms_pkg.sv
// ----------------------------------------------------------------------------
// enms_pkg: shared definitions for the edge non-maximum suppression unit
// Field widths, register map, queue sizing, job and bounds types, and the
// direction-code to neighbour-pair table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package enms_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int WINDOW_SIZE    = 3;

	localparam int CHAN_W  = 8;
	localparam int ANGLE_W = 8;
	localparam int PIXEL_W = 3 * CHAN_W;

	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// register index, taken from the word address
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam int QUEUE_DEPTH   = 4;
	localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 1);

	typedef logic [CHAN_W-1:0]  chan_t;
	typedef logic [ANGLE_W-1:0] angle_t;
	typedef logic [PIXEL_W-1:0] pixel_t;

	typedef enum logic [1:0] {
		PAIR_HORZ,       // left and right
		PAIR_DIAG_FALL,  // upper-left and lower-right
		PAIR_VERT,       // above and below
		PAIR_DIAG_RISE   // upper-right and lower-left
	} pair_t;

	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} bounds_t;

	typedef struct packed {
		pixel_t centre;
		chan_t  red_a;
		chan_t  red_b;
		logic   frame_end;
	} job_t;

	function automatic chan_t red_of(input pixel_t px);
		return px[PIXEL_W-1 -: CHAN_W];
	endfunction

	// Degrees are floor(code*360/255), folded by 180 above 180. The sector edges
	// at 22.5, 67.5, 112.5 and 157.5 degrees land on these code ranges.
	function automatic pair_t pair_of(input angle_t code);
		pair_t pair;
		case (code) inside
			[8'd17:8'd48], [8'd144:8'd175]:  pair = PAIR_DIAG_FALL;
			[8'd49:8'd80], [8'd176:8'd207]:  pair = PAIR_VERT;
			[8'd81:8'd111], [8'd208:8'd239]: pair = PAIR_DIAG_RISE;
			default:                         pair = PAIR_HORZ;
		endcase
		return pair;
	endfunction

endpackage

FILE: hdl/enms_if.sv
// ----------------------------------------------------------------------------
// enms_if: stream channels of the edge non-maximum suppression unit
// Pixel channel in, result channel out; valid/ready with the payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface enms_pix_if;
	logic                  valid;
	logic                  ready;
	logic [enms_pkg::CHAN_W-1:0]  mag_red;
	logic [enms_pkg::CHAN_W-1:0]  mag_green;
	logic [enms_pkg::CHAN_W-1:0]  mag_blue;
	logic [enms_pkg::ANGLE_W-1:0] angle_code;
	logic                  flush;

	modport source (output valid, mag_red, mag_green, mag_blue, angle_code, flush,
		input ready);
	modport sink (input valid, mag_red, mag_green, mag_blue, angle_code, flush,
		output ready);
endinterface

interface enms_res_if;
	logic                  valid;
	logic                  ready;
	logic [enms_pkg::CHAN_W-1:0] out_red;
	logic [enms_pkg::CHAN_W-1:0] out_green;
	logic [enms_pkg::CHAN_W-1:0] out_blue;
	logic                  frame_end;

	modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
	modport sink (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

FILE: hdl/edge_non_max_suppression_unit.sv
// ----------------------------------------------------------------------------
// edge_non_max_suppression_unit: 3x3 non-maximum suppression on a pixel stream
// Throughput: one pixel per clock, set by the line stores, which take one
//   read and one write per cycle each; a queue stall holds intake.
// Path: the pixel that completes a window passes stage 1, the window and
//   stage 2, the queue and the result register; the centre trails it by a row and a column.
// Reset: counters clear, width 640 and height 480, window zero, queue empty;
//   the line stores are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edge_non_max_suppression_unit #(
	parameter int MAX_WIDTH  = enms_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = enms_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	enms_pix_if.sink                        pixel,
	enms_res_if.source                      result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [enms_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [enms_pkg::APB_DATA_W-1:0] pwdata,
	output logic [enms_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	// clamped image size and the frame restart from a register write
	logic [WW-1:0] width;
	logic [HW-1:0] height;
	logic          restart;

	// front to queue
	logic           q_push;
	enms_pkg::job_t q_job_in;

	// queue to back
	logic                               q_pop;
	logic                               q_not_empty;
	enms_pkg::job_t                     q_job_out;
	logic [enms_pkg::QUEUE_LEVEL_W-1:0] q_level;

	// Register block: image width at byte address 0, height at 4. Both are
	// clamped to 1..MAX before use; a write restarts the frame at once while
	// window and line stores keep their contents.
	enms_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.width   (width),
		.height  (height),
		.restart (restart)
	);

	// Front: takes one pixel per transfer (flush items as black pixels),
	// advances the raster position, reads and rewrites the line stores,
	// shifts the window and, for a centre inside the image, hands the centre
	// pixel and its masked neighbour reds to the queue. Intake only stalls
	// when the queue could not absorb the items already in the pipe.
	enms_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pixel),
		.width   (width),
		.height  (height),
		.restart (restart),
		.q_level (q_level),
		.push    (q_push),
		.job     (q_job_in)
	);

	// Queue: decouples the two halves so that a stalled consumer does not
	// stop the window pipeline until the queue fills.
	enms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.job_in    (q_job_in),
		.pop       (q_pop),
		.job_out   (q_job_out),
		.not_empty (q_not_empty),
		.level     (q_level)
	);

	// Back: compares the centre red against the chosen pair and registers the
	// kept or blacked-out pixel, refilled on the same edge as its transfer, so
	// one result per clock leaves while jobs wait and the consumer is ready.
	enms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (q_job_out),
		.job_valid (q_not_empty),
		.pop       (q_pop),
		.result    (result)
	);

	// the intake credit check must keep the queue from overflowing
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_level < enms_pkg::QUEUE_LEVEL_W'(enms_pkg::QUEUE_DEPTH)))
		else $error("job pushed into a full queue");

	// the back only drains jobs that are there
	a_pop_filled: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_level != '0))
		else $error("job popped from an empty queue");

	// a new result must come from a job queued in the cycle before
	a_result_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> ($past(q_level) != '0))
		else $error("result raised without a queued job");

endmodule

FILE: hdl/enms_cfg.sv
// ----------------------------------------------------------------------------
// enms_cfg: configuration registers
// APB-style image width and height, clamped copies for the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module enms_cfg #(
	parameter int MAX_WIDTH  = enms_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = enms_pkg::DEF_MAX_HEIGHT,
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [enms_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [enms_pkg::APB_DATA_W-1:0] pwdata,
	output logic [enms_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	output logic [WW-1:0]                   width,
	output logic [HW-1:0]                   height,
	output logic                            restart
);

	localparam int WIDTH_EFF_RESET  =
		(enms_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : enms_pkg::WIDTH_RESET;
	localparam int HEIGHT_EFF_RESET =
		(enms_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : enms_pkg::HEIGHT_RESET;

	logic [enms_pkg::WIDTH_REG_W-1:0]  width_raw_q;
	logic [enms_pkg::HEIGHT_REG_W-1:0] height_raw_q;
	logic [WW-1:0]                     width_q;
	logic [HW-1:0]                     height_q;
	logic [enms_pkg::WIDTH_REG_W-1:0]  wr_width;
	logic [enms_pkg::HEIGHT_REG_W-1:0] wr_height;
	logic [WW-1:0]                     width_clamp;
	logic [HW-1:0]                     height_clamp;
	logic                              wr;
	logic                              reg_sel;

	assign pready    = 1'b1;
	assign wr        = psel && penable && pwrite && pready;
	assign reg_sel   = paddr[enms_pkg::APB_ADDR_W-1];
	assign wr_width  = pwdata[enms_pkg::WIDTH_REG_W-1:0];
	assign wr_height = pwdata[enms_pkg::HEIGHT_REG_W-1:0];

	// clamp into 1..MAX
	always_comb begin
		if (wr_width == '0) begin
			width_clamp = WW'(1);
		end else if (32'(wr_width) > 32'(MAX_WIDTH)) begin
			width_clamp = WW'(MAX_WIDTH);
		end else begin
			width_clamp = WW'(wr_width);
		end
		if (wr_height == '0) begin
			height_clamp = HW'(1);
		end else if (32'(wr_height) > 32'(MAX_HEIGHT)) begin
			height_clamp = HW'(MAX_HEIGHT);
		end else begin
			height_clamp = HW'(wr_height);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_raw_q  <= enms_pkg::WIDTH_REG_W'(enms_pkg::WIDTH_RESET);
			height_raw_q <= enms_pkg::HEIGHT_REG_W'(enms_pkg::HEIGHT_RESET);
			width_q      <= WW'(WIDTH_EFF_RESET);
			height_q     <= HW'(HEIGHT_EFF_RESET);
		end else if (wr) begin
			case (reg_sel)
				enms_pkg::REG_IMAGE_WIDTH: begin
					width_raw_q <= wr_width;
					width_q     <= width_clamp;
				end
				enms_pkg::REG_IMAGE_HEIGHT: begin
					height_raw_q <= wr_height;
					height_q     <= height_clamp;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			enms_pkg::REG_IMAGE_WIDTH:  prdata = enms_pkg::APB_DATA_W'(width_raw_q);
			enms_pkg::REG_IMAGE_HEIGHT: prdata = enms_pkg::APB_DATA_W'(height_raw_q);
			default:                    prdata = '0;
		endcase
	end

	// any write restarts the frame at the same edge
	assign restart = wr;
	assign width   = width_q;
	assign height  = height_q;

endmodule

FILE: hdl/enms_front.sv
// ----------------------------------------------------------------------------
// enms_front: pixel intake, line stores and window
// Tracks the raster position, builds the 3x3 window and issues one
// compare job per centre pixel that lies inside the image.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module enms_front #(
	parameter int MAX_WIDTH  = enms_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = enms_pkg::DEF_MAX_HEIGHT,
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	enms_pix_if.sink                           pixel,
	input  logic [WW-1:0]                      width,
	input  logic [HW-1:0]                      height,
	input  logic                               restart,
	input  logic [enms_pkg::QUEUE_LEVEL_W-1:0] q_level,
	output logic                               push,
	output enms_pkg::job_t                     job
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
	localparam int SUM_W = enms_pkg::QUEUE_LEVEL_W + 1;
	localparam int LAST  = enms_pkg::WINDOW_SIZE - 1;

	// line stores, read-first
	enms_pkg::pixel_t upper_mem  [MAX_WIDTH];
	enms_pkg::pixel_t middle_mem [MAX_WIDTH];
	enms_pkg::angle_t angle_mem  [MAX_WIDTH];

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [SUM_W-1:0] committed;
	logic             accept;

	// intake decode
	logic             col_zero;
	logic [ROW_W-1:0] row_m;
	logic [ROW_W-1:0] h_ext;
	logic [WW-1:0]    col_inc;
	logic             emit_s0;
	logic             fend_s0;
	enms_pkg::bounds_t bounds_s0;
	enms_pkg::pixel_t px_s0;
	enms_pkg::angle_t ang_s0;

	// stage 1
	logic              valid_s1;
	logic [COL_W-1:0]  addr_s1;
	enms_pkg::pixel_t  px_s1;
	enms_pkg::angle_t  ang_s1;
	logic              emit_s1;
	logic              fend_s1;
	enms_pkg::bounds_t bounds_s1;
	logic              byp_s1;
	enms_pkg::pixel_t  fwd_up_s1;
	enms_pkg::pixel_t  fwd_mid_s1;
	enms_pkg::angle_t  fwd_ang_s1;
	enms_pkg::pixel_t  rd_up_s1;
	enms_pkg::pixel_t  rd_mid_s1;
	enms_pkg::angle_t  rd_ang_s1;
	enms_pkg::pixel_t  up_eff;
	enms_pkg::pixel_t  mid_eff;
	enms_pkg::angle_t  ang_eff;

	// window and stage 2
	enms_pkg::pixel_t  win_q [enms_pkg::WINDOW_SIZE][enms_pkg::WINDOW_SIZE];
	enms_pkg::angle_t  angle_col_q;
	logic              valid_s2;
	logic              emit_s2;
	logic              fend_s2;
	enms_pkg::bounds_t bounds_s2;
	enms_pkg::pair_t   pair_s2;

	// hold intake while the queue cannot take everything in flight
	assign committed = SUM_W'(q_level) + SUM_W'(valid_s1) + SUM_W'(valid_s2);
	assign pixel.ready = committed < SUM_W'(enms_pkg::QUEUE_DEPTH);
	assign accept = pixel.valid && pixel.ready;

	// At column zero the centre is the last column two rows up, else the
	// previous column one row up. row_m is the row one below the centre.
	assign col_zero = (col_q == '0);
	assign row_m    = col_zero ? row_q - 1'b1 : row_q;
	assign h_ext    = ROW_W'(height);
	assign col_inc  = WW'(col_q) + 1'b1;

	assign emit_s0          = (row_m != '0) && (row_m <= h_ext);
	assign fend_s0          = col_zero && (row_m == h_ext);
	assign bounds_s0.top    = row_m >= ROW_W'(2);
	assign bounds_s0.bottom = row_m < h_ext;
	assign bounds_s0.left   = col_zero ? (width >= WW'(2)) : (col_q >= COL_W'(2));
	assign bounds_s0.right  = !col_zero;

	assign px_s0  = pixel.flush ? '0 : {pixel.mag_red, pixel.mag_green, pixel.mag_blue};
	assign ang_s0 = pixel.flush ? '0 : pixel.angle_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (fend_s0) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc == width) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_up_s1 <= upper_mem[col_q];
		end
		if (valid_s1) begin
			upper_mem[addr_s1] <= mid_eff;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_mid_s1 <= middle_mem[col_q];
		end
		if (valid_s1) begin
			middle_mem[addr_s1] <= px_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ang_s1 <= angle_mem[col_q];
		end
		if (valid_s1) begin
			angle_mem[addr_s1] <= ang_s1;
		end
	end

	// a read that meets the write of the same column takes that write's data
	assign up_eff  = byp_s1 ? fwd_up_s1  : rd_up_s1;
	assign mid_eff = byp_s1 ? fwd_mid_s1 : rd_mid_s1;
	assign ang_eff = byp_s1 ? fwd_ang_s1 : rd_ang_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1    <= col_q;
			px_s1      <= px_s0;
			ang_s1     <= ang_s0;
			emit_s1    <= emit_s0;
			fend_s1    <= fend_s0;
			bounds_s1  <= bounds_s0;
			byp_s1     <= valid_s1 && (addr_s1 == col_q);
			fwd_up_s1  <= mid_eff;
			fwd_mid_s1 <= px_s1;
			fwd_ang_s1 <= ang_s1;
		end
		if (valid_s1) begin
			emit_s2   <= emit_s1;
			fend_s2   <= fend_s1;
			bounds_s2 <= bounds_s1;
			pair_s2   <= enms_pkg::pair_of(angle_col_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			angle_col_q <= '0;
			for (int r = 0; r < enms_pkg::WINDOW_SIZE; r++) begin
				for (int k = 0; k < enms_pkg::WINDOW_SIZE; k++) begin
					win_q[r][k] <= '0;
				end
			end
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				// shift left, new column on the right, oldest row on top
				for (int r = 0; r < enms_pkg::WINDOW_SIZE; r++) begin
					for (int k = 0; k < LAST; k++) begin
						win_q[r][k] <= win_q[r][k+1];
					end
				end
				win_q[0][LAST] <= up_eff;
				win_q[1][LAST] <= mid_eff;
				win_q[2][LAST] <= px_s1;
				angle_col_q    <= ang_eff;
			end
		end
	end

	// pick and mask the neighbour pair
	always_comb begin
		job.centre    = win_q[1][1];
		job.frame_end = fend_s2;
		case (pair_s2)
			enms_pkg::PAIR_HORZ: begin
				job.red_a = bounds_s2.left  ? enms_pkg::red_of(win_q[1][0]) : '0;
				job.red_b = bounds_s2.right ? enms_pkg::red_of(win_q[1][2]) : '0;
			end
			enms_pkg::PAIR_DIAG_FALL: begin
				job.red_a = (bounds_s2.top && bounds_s2.left) ?
					enms_pkg::red_of(win_q[0][0]) : '0;
				job.red_b = (bounds_s2.bottom && bounds_s2.right) ?
					enms_pkg::red_of(win_q[2][2]) : '0;
			end
			enms_pkg::PAIR_VERT: begin
				job.red_a = bounds_s2.top    ? enms_pkg::red_of(win_q[0][1]) : '0;
				job.red_b = bounds_s2.bottom ? enms_pkg::red_of(win_q[2][1]) : '0;
			end
			enms_pkg::PAIR_DIAG_RISE: begin
				job.red_a = (bounds_s2.top && bounds_s2.right) ?
					enms_pkg::red_of(win_q[0][2]) : '0;
				job.red_b = (bounds_s2.bottom && bounds_s2.left) ?
					enms_pkg::red_of(win_q[2][0]) : '0;
			end
			default: begin
				job.red_a = '0;
				job.red_b = '0;
			end
		endcase
	end

	assign push = valid_s2 && emit_s2;

endmodule

FILE: hdl/enms_queue.sv
// ----------------------------------------------------------------------------
// enms_queue: job queue
// Short first-in first-out buffer between the window front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module enms_queue (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  enms_pkg::job_t                     job_in,
	input  logic                               pop,
	output enms_pkg::job_t                     job_out,
	output logic                               not_empty,
	output logic [enms_pkg::QUEUE_LEVEL_W-1:0] level
);

	enms_pkg::job_t                   slot_q [enms_pkg::QUEUE_DEPTH];
	logic [enms_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [enms_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [enms_pkg::QUEUE_LEVEL_W-1:0] level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

	assign job_out   = slot_q[rd_ptr_q];
	assign not_empty = (level_q != '0);
	assign level     = level_q;

endmodule

FILE: hdl/enms_back.sv
// ----------------------------------------------------------------------------
// enms_back: suppression compare and result register
// Keeps the centre pixel when its red is at least both neighbours' reds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module enms_back (
	input  logic           clk,
	input  logic           arst_n,
	input  enms_pkg::job_t job,
	input  logic           job_valid,
	output logic           pop,
	enms_res_if.source     result
);

	logic             out_valid_q;
	enms_pkg::pixel_t out_pix_q;
	logic             out_fend_q;
	enms_pkg::chan_t  centre_red;
	logic             keep;

	assign centre_red = enms_pkg::red_of(job.centre);
	assign keep       = (centre_red >= job.red_a) && (centre_red >= job.red_b);

	// advance when the result register is free or being drained
	assign pop = job_valid && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_pix_q  <= keep ? job.centre : '0;
			out_fend_q <= job.frame_end;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_red   = out_pix_q[enms_pkg::PIXEL_W-1 -: enms_pkg::CHAN_W];
	assign result.out_green = out_pix_q[2*enms_pkg::CHAN_W-1 -: enms_pkg::CHAN_W];
	assign result.out_blue  = out_pix_q[enms_pkg::CHAN_W-1:0];
	assign result.frame_end = out_fend_q;

endmodule

FILE: tb/sv/edge_non_max_suppression_unit_test.sv
// ----------------------------------------------------------------------------
// edge_non_max_suppression_unit_test: self-checking bench for the 3x3 NMS unit
// Streams raster frames of magnitude pixels with direction codes through the
// unit, works out each expected suppression result with its own line stores
// and window, and compares every result transfer field by field. Frame sizes
// are changed over the register port between frames and part-way through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edge_non_max_suppression_unit_test;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int RANDOM_ITEMS  = 1430;
	// the tail of the random part runs with both sides always willing
	localparam int QUIET_ITEMS   = 250;
	// let the last results leave and the output queue empty
	localparam int SETTLE_CYCLES = 10;
	// bound for the slowest correct run of roughly 2k items, plus the
	// register traffic and settling between frames
	localparam int CYCLE_LIMIT   = 800000;

	// folded-degree sector edges: horizontal up to 22 and from 158,
	// falling diagonal up to 67, vertical up to 112, rising diagonal beyond
	localparam int HORZ_LOW_LAST  = 22;
	localparam int HORZ_HIGH_LIFT = 158;
	localparam int DIAG_FALL_LAST = 67;
	localparam int VERT_LAST      = 112;
	localparam int FULL_TURN      = 360;
	localparam int HALF_TURN      = 180;
	localparam int CODE_SPAN      = 255;

	// slots of the 3x3 window, oldest row on top
	localparam int UP_LEFT    = 0;
	localparam int UP         = 1;
	localparam int UP_RIGHT   = 2;
	localparam int MID_LEFT   = 3;
	localparam int CENTRE     = 4;
	localparam int MID_RIGHT  = 5;
	localparam int DOWN_LEFT  = 6;
	localparam int DOWN       = 7;
	localparam int DOWN_RIGHT = 8;

	localparam int PIX_W = enms_pkg::PIXEL_W;
	localparam int CH_W  = enms_pkg::CHAN_W;

	typedef struct packed {
		logic             flush;
		enms_pkg::chan_t  red;
		enms_pkg::chan_t  green;
		enms_pkg::chan_t  blue;
		enms_pkg::angle_t code;
	} pix_item_t;

	typedef struct packed {
		enms_pkg::chan_t red;
		enms_pkg::chan_t green;
		enms_pkg::chan_t blue;
		logic            frame_end;
	} nms_result_t;

	logic                            clk     = 1'b0;
	logic                            arst_n  = 1'b0;
	logic                            psel    = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite  = 1'b0;
	logic [enms_pkg::APB_ADDR_W-1:0] paddr   = '0;
	logic [enms_pkg::APB_DATA_W-1:0] pwdata  = '0;
	logic [enms_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;

	enms_pix_if pix_bus ();
	enms_res_if res_bus ();

	edge_non_max_suppression_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pix_bus),
		.result  (res_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Stimulus waiting for the driver, and suppression results still owed
	pix_item_t   pending_pixels[$];
	nms_result_t expected_results[$];

	// Own copy of the unit: registers, line stores, window and raster position.
	// Stores start at zero here; entries the unit has never written are always
	// outside the image bounds when they reach the window, so this is harmless.
	logic [enms_pkg::WIDTH_REG_W-1:0]  width_reg  = enms_pkg::WIDTH_RESET;
	logic [enms_pkg::HEIGHT_REG_W-1:0] height_reg = enms_pkg::HEIGHT_RESET;
	enms_pkg::pixel_t upper_row   [enms_pkg::DEF_MAX_WIDTH] = '{default: '0};
	enms_pkg::pixel_t middle_row  [enms_pkg::DEF_MAX_WIDTH] = '{default: '0};
	enms_pkg::angle_t middle_code [enms_pkg::DEF_MAX_WIDTH] = '{default: '0};
	enms_pkg::pixel_t win         [9]                       = '{default: '0};
	enms_pkg::angle_t code_col    [3]                       = '{default: '0};
	int     col_pos = 0;
	int     row_pos = 0;

	bit          idle_on   = 1'b1;
	bit          pix_taken = 1'b0;
	int          src_gap   = 0;
	int          snk_gap   = 0;
	int unsigned fail_count  = 0;
	int unsigned cycle_count = 0;
	pix_item_t   drive_item;
	pix_item_t   seen_item;
	nms_result_t owed;

	always #HALF_PERIOD clk = ~clk;

	initial begin
		pix_bus.valid      = 1'b0;
		pix_bus.mag_red    = '0;
		pix_bus.mag_green  = '0;
		pix_bus.mag_blue   = '0;
		pix_bus.angle_code = '0;
		pix_bus.flush      = 1'b0;
		res_bus.ready      = 1'b0;
	end

	// Advance the raster by one pixel and owe a result when the window centre
	// lies inside the image.
	task automatic predict_suppression(input pix_item_t item);
		int               w, h, c, cr, cc, deg, yy, xx, r;
		enms_pkg::pixel_t px, centre;
		enms_pkg::angle_t code;
		enms_pkg::pixel_t nb [9];
		enms_pkg::chan_t  red_a, red_b, red_c;
		enms_pkg::pair_t  pair;
		logic             fend;
		nms_result_t      res;
		w = (width_reg == 0) ? 1 :
			(width_reg > enms_pkg::DEF_MAX_WIDTH) ? enms_pkg::DEF_MAX_WIDTH : int'(width_reg);
		h = (height_reg == 0) ? 1 :
			(height_reg > enms_pkg::DEF_MAX_HEIGHT) ? enms_pkg::DEF_MAX_HEIGHT :
			int'(height_reg);
		c = (col_pos >= w) ? w - 1 : col_pos;
		// a drain item reads as a black pixel pointing along code zero
		px   = item.flush ? '0 : {item.red, item.green, item.blue};
		code = item.flush ? '0 : item.code;

		for (r = 0; r < 3; r++) begin
			win[3*r]     = win[3*r + 1];
			win[3*r + 1] = win[3*r + 2];
		end
		win[UP_RIGHT]   = upper_row[c];
		win[MID_RIGHT]  = middle_row[c];
		win[DOWN_RIGHT] = px;
		code_col[0] = code_col[1];
		code_col[1] = code_col[2];
		code_col[2] = middle_code[c];
		upper_row[c]   = middle_row[c];
		middle_row[c]  = px;
		middle_code[c] = code;

		// the centre trails the input by a row and a column
		if (c > 0) begin
			cr = row_pos - 1;
			cc = c - 1;
		end else begin
			cr = row_pos - 2;
			cc = w - 1;
		end
		c++;
		if (c >= w) begin
			c = 0;
			row_pos++;
		end
		col_pos = c;

		if (cr >= 0 && cr < h) begin
			fend = (cr == h - 1) && (cc == w - 1);
			if (fend) begin
				col_pos = 0;
				row_pos = 0;
			end
			// mask neighbours that fall outside the image, stale store data included
			for (r = 0; r < 9; r++) begin
				yy = cr + r / 3 - 1;
				xx = cc + r % 3 - 1;
				nb[r] = (yy >= 0 && yy < h && xx >= 0 && xx < w) ? win[r] : '0;
			end
			deg = int'(code_col[1]) * FULL_TURN / CODE_SPAN;
			if (deg > HALF_TURN)
				deg -= HALF_TURN;
			if (deg <= HORZ_LOW_LAST || deg >= HORZ_HIGH_LIFT)
				pair = enms_pkg::PAIR_HORZ;
			else if (deg <= DIAG_FALL_LAST)
				pair = enms_pkg::PAIR_DIAG_FALL;
			else if (deg <= VERT_LAST)
				pair = enms_pkg::PAIR_VERT;
			else
				pair = enms_pkg::PAIR_DIAG_RISE;
			case (pair)
				enms_pkg::PAIR_HORZ: begin
					red_a = nb[MID_LEFT][PIX_W-1 -: CH_W];
					red_b = nb[MID_RIGHT][PIX_W-1 -: CH_W];
				end
				enms_pkg::PAIR_DIAG_FALL: begin
					red_a = nb[UP_LEFT][PIX_W-1 -: CH_W];
					red_b = nb[DOWN_RIGHT][PIX_W-1 -: CH_W];
				end
				enms_pkg::PAIR_VERT: begin
					red_a = nb[UP][PIX_W-1 -: CH_W];
					red_b = nb[DOWN][PIX_W-1 -: CH_W];
				end
				default: begin
					red_a = nb[UP_RIGHT][PIX_W-1 -: CH_W];
					red_b = nb[DOWN_LEFT][PIX_W-1 -: CH_W];
				end
			endcase
			centre = nb[CENTRE];
			red_c  = centre[PIX_W-1 -: CH_W];
			// ties keep the centre
			if (red_c < red_a || red_c < red_b)
				centre = '0;
			res.red       = centre[PIX_W-1 -: CH_W];
			res.green     = centre[CH_W +: CH_W];
			res.blue      = centre[0 +: CH_W];
			res.frame_end = fend;
			expected_results.push_back(res);
		end
	endtask

	// Setup cycle, then access cycle; the register takes the value at the
	// rising edge of the access cycle, which also restarts the frame.
	task automatic apb_write(input logic reg_idx,
		input logic [enms_pkg::APB_DATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (reg_idx == enms_pkg::REG_IMAGE_WIDTH)
			width_reg = value[enms_pkg::WIDTH_REG_W-1:0];
		else
			height_reg = value[enms_pkg::HEIGHT_REG_W-1:0];
		col_pos = 0;
		row_pos = 0;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_register(input logic reg_idx);
		logic [enms_pkg::APB_DATA_W-1:0] want;
		want = (reg_idx == enms_pkg::REG_IMAGE_WIDTH) ?
			enms_pkg::APB_DATA_W'(width_reg) : enms_pkg::APB_DATA_W'(height_reg);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {reg_idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			$error("%s: expected %0d, got %0d",
				(reg_idx == enms_pkg::REG_IMAGE_WIDTH) ? "image_width" : "image_height",
				want, prdata);
			fail_count++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_frame(input logic [enms_pkg::APB_DATA_W-1:0] w_val, h_val);
		apb_write(enms_pkg::REG_IMAGE_WIDTH, w_val);
		apb_write(enms_pkg::REG_IMAGE_HEIGHT, h_val);
		check_register(enms_pkg::REG_IMAGE_WIDTH);
		check_register(enms_pkg::REG_IMAGE_HEIGHT);
	endtask

	// Hold until nothing is queued, in flight or owed, then let the pipeline settle
	task automatic wait_idle;
		while (pending_pixels.size() != 0 || pix_bus.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Channel values lean towards the extremes so that red ties turn up often
	function automatic enms_pkg::chan_t rand_chan();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return enms_pkg::chan_t'($urandom_range(0, 255));
	endfunction

	function automatic void add_pixel(input logic fl, input enms_pkg::chan_t r, g, b,
		input enms_pkg::angle_t a);
		pix_item_t item;
		item.flush = fl;
		item.red   = r;
		item.green = g;
		item.blue  = b;
		item.code  = a;
		pending_pixels.push_back(item);
	endfunction

	// Data is random for drain items too: the unit must ignore it
	function automatic void add_random(input logic fl);
		add_pixel(fl, rand_chan(), rand_chan(), rand_chan(),
			enms_pkg::angle_t'($urandom_range(0, 255)));
	endfunction

	// One whole frame plus its W+1 drain items; with noise, drop the odd
	// flush into the frame and use pixel items for some of the drain.
	function automatic int add_frame(input int w, h, input bit noisy);
		int n;
		for (n = 0; n < w * h; n++)
			add_random(noisy && $urandom_range(0, 15) == 0);
		for (n = 0; n < w + 1; n++)
			add_random(!(noisy && $urandom_range(0, 3) == 0));
		return w * h + w + 1;
	endfunction

	// Pixel driver: change at the falling edge, hold until the transfer
	always @(negedge clk) begin
		if (!pix_bus.valid || pix_taken) begin
			pix_taken = 1'b0;
			if (src_gap > 0) begin
				src_gap--;
				pix_bus.valid <= 1'b0;
			end else if (pending_pixels.size() > 0) begin
				drive_item = pending_pixels.pop_front();
				pix_bus.valid      <= 1'b1;
				pix_bus.flush      <= drive_item.flush;
				pix_bus.mag_red    <= drive_item.red;
				pix_bus.mag_green  <= drive_item.green;
				pix_bus.mag_blue   <= drive_item.blue;
				pix_bus.angle_code <= drive_item.code;
				if (idle_on && $urandom_range(0, 5) == 0)
					src_gap = $urandom_range(1, 16);
			end else begin
				pix_bus.valid <= 1'b0;
			end
		end
	end

	// Result receiver: stall in bursts while idling is allowed
	always @(negedge clk) begin
		if (snk_gap > 0) begin
			snk_gap--;
			res_bus.ready <= 1'b0;
		end else begin
			res_bus.ready <= 1'b1;
			if (idle_on && $urandom_range(0, 5) == 0)
				snk_gap = $urandom_range(1, 16);
		end
	end

	// Monitor: check result transfers, then predict from pixel transfers.
	// A pixel cannot cause a result at its own edge, so the order is safe.
	always @(posedge clk) begin
		if (res_bus.valid && res_bus.ready) begin
			if (expected_results.size() == 0) begin
				$error("result with no expectation: red %0d green %0d blue %0d frame_end %0b",
					res_bus.out_red, res_bus.out_green, res_bus.out_blue, res_bus.frame_end);
				fail_count++;
			end else begin
				owed = expected_results.pop_front();
				if (res_bus.out_red !== owed.red) begin
					$error("out_red: expected %0d, got %0d", owed.red, res_bus.out_red);
					fail_count++;
				end
				if (res_bus.out_green !== owed.green) begin
					$error("out_green: expected %0d, got %0d", owed.green, res_bus.out_green);
					fail_count++;
				end
				if (res_bus.out_blue !== owed.blue) begin
					$error("out_blue: expected %0d, got %0d", owed.blue, res_bus.out_blue);
					fail_count++;
				end
				if (res_bus.frame_end !== owed.frame_end) begin
					$error("frame_end: expected %0b, got %0b", owed.frame_end, res_bus.frame_end);
					fail_count++;
				end
			end
		end
		if (pix_bus.valid && pix_bus.ready) begin
			seen_item.flush = pix_bus.flush;
			seen_item.red   = pix_bus.mag_red;
			seen_item.green = pix_bus.mag_green;
			seen_item.blue  = pix_bus.mag_blue;
			seen_item.code  = pix_bus.angle_code;
			predict_suppression(seen_item);
			pix_taken = 1'b1;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int w, h, cut, n, random_count;
		random_count = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// reset values read back before anything is written
		check_register(enms_pkg::REG_IMAGE_WIDTH);
		check_register(enms_pkg::REG_IMAGE_HEIGHT);

		// Directed 3x3 frame: channel extremes, codes either side of each sector
		// edge, a red tie beside the centre, and a flush as the first pixel
		set_frame(3, 3);
		add_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'd200);
		add_pixel(1'b0, 8'hFF, 8'h00, 8'hFF, 8'd16);
		add_pixel(1'b0, 8'h80, 8'h55, 8'hAA, 8'd17);
		add_pixel(1'b0, 8'h40, 8'hFF, 8'hFF, 8'd48);
		add_pixel(1'b0, 8'hC0, 8'h12, 8'h34, 8'd49);
		add_pixel(1'b0, 8'hC0, 8'h00, 8'h00, 8'd80);
		add_pixel(1'b0, 8'h01, 8'hFE, 8'h01, 8'd81);
		add_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'd111);
		add_pixel(1'b0, 8'h00, 8'h00, 8'h00, 8'd112);
		for (n = 0; n < 4; n++)
			add_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		// second frame straight after the first, drained by pixel items
		add_pixel(1'b0, 8'h10, 8'h20, 8'h30, 8'd143);
		add_pixel(1'b0, 8'hFF, 8'h00, 8'h00, 8'd144);
		add_pixel(1'b0, 8'h7F, 8'h80, 8'h81, 8'd175);
		add_pixel(1'b0, 8'h00, 8'hFF, 8'h00, 8'd176);
		add_pixel(1'b0, 8'hFE, 8'hAA, 8'h55, 8'd207);
		add_pixel(1'b0, 8'hFF, 8'h01, 8'h02, 8'd208);
		add_pixel(1'b0, 8'h33, 8'h44, 8'h55, 8'd239);
		add_pixel(1'b0, 8'hFE, 8'hFF, 8'hFF, 8'd240);
		add_pixel(1'b0, 8'h80, 8'h00, 8'hFF, 8'd255);
		for (n = 0; n < 4; n++)
			add_random(1'b0);
		wait_idle();

		// Register extremes: zero and overlarge values clamp to the limits.
		// Zero width runs as a single column; the frame is only started and
		// the next write restarts it.
		set_frame(0, 8191);
		for (n = 0; n < 40; n++)
			add_random(1'b0);
		wait_idle();
		// zero height runs as a single row
		set_frame(2, 0);
		void'(add_frame(2, 1, 1'b0));
		wait_idle();
		set_frame(1, 1);
		void'(add_frame(1, 1, 1'b0));
		wait_idle();
		// overlarge sizes: start a frame only, the next write restarts it
		set_frame(2047, 8191);
		for (n = 0; n < 40; n++)
			add_random(1'b0);
		wait_idle();

		// Random frames, mostly small and well formed; some are broken off
		// part-way and restarted by rewriting a single register
		while (random_count < RANDOM_ITEMS) begin
			if (random_count >= RANDOM_ITEMS - QUIET_ITEMS)
				idle_on = 1'b0;
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			h = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
			set_frame(w, h);
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 4) == 0) begin
					cut = $urandom_range(1, w * h + w);
					for (n = 0; n < cut; n++)
						add_random($urandom_range(0, 15) == 0);
					random_count += cut;
					wait_idle();
					if ($urandom_range(0, 1))
						apb_write(enms_pkg::REG_IMAGE_WIDTH, w);
					else
						apb_write(enms_pkg::REG_IMAGE_HEIGHT, h);
				end else begin
					random_count += add_frame(w, h, 1'b1);
				end
			end
			wait_idle();
		end

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
hdl/enms_pkg.sv
hdl/enms_if.sv
hdl/enms_cfg.sv
hdl/enms_front.sv
hdl/enms_queue.sv
hdl/enms_back.sv
hdl/edge_non_max_suppression_unit.sv
tb/sv/edge_non_max_suppression_unit_test.sv
